### hw/rtl/mbx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_pkg
// Shared constants, codes and types of the bounded message mailbox.
// ----------------------------------------------------------------------------
package mbx_pkg;

  localparam int MSG_DEPTH  = 16;
  localparam int BYTE_DEPTH = 1024;

  localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int BYTE_AW   = $clog2(BYTE_DEPTH);
  localparam int CNT_W     = 5;
  localparam int LEN_W     = 11;
  localparam int SENDER_W  = 64;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DW    = 11;
  localparam int DESC_W    = SENDER_W + LEN_W;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_LIMIT = 1'b1;

  localparam logic [CNT_W-1:0] MSG_LIMIT_RST  = CNT_W'(16);
  localparam logic [LEN_W-1:0] BYTE_LIMIT_RST = LEN_W'(1024);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_COUNT_FULL  = 3'd1,
    ST_BYTES_FULL  = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_IGNORED     = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic latch;   // capture the input beat, memory reads in flight
    logic commit;  // apply the beat, load the result register
  } mbx_cmd_t;

endpackage

### hw/rtl/mbx_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_in_if
// Request channel of the mailbox: push and pop beats.
// ----------------------------------------------------------------------------
interface mbx_in_if;
  import mbx_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [SENDER_W-1:0] sender_id;
  logic [LEN_W-1:0]    msg_length;
  logic [BYTE_W-1:0]   data_byte;
  logic                first_beat;

  modport source (
    output valid, action, sender_id, msg_length, data_byte, first_beat,
    input  ready
  );

  modport sink (
    input  valid, action, sender_id, msg_length, data_byte, first_beat,
    output ready
  );

endinterface

### hw/rtl/mbx_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_out_if
// Result channel of the mailbox: one result beat per request beat.
// ----------------------------------------------------------------------------
interface mbx_out_if;
  import mbx_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [SENDER_W-1:0] out_sender_id;
  logic [LEN_W-1:0]    out_length;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [CNT_W-1:0]    message_count;
  logic [LEN_W-1:0]    bytes_in_use;

  modport source (
    output valid, status, out_sender_id, out_length, out_byte, out_last,
           message_count, bytes_in_use,
    input  ready
  );

  modport sink (
    input  valid, status, out_sender_id, out_length, out_byte, out_last,
           message_count, bytes_in_use,
    output ready
  );

endinterface

### hw/rtl/mbx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mbx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_ctrl
// Sequencer: accept a beat, wait in S_EXEC for the registered memory data,
// then commit once the result register is free.
// ----------------------------------------------------------------------------
module mbx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mbx_pkg::mbx_cmd_t cmd
);
  import mbx_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the previous result beat has left
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/mbx_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbx_dp
// Mailbox datapath: payload ring, descriptor ring, pointers, counters,
// limit registers and the result register.
// ----------------------------------------------------------------------------
module mbx_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mbx_pkg::mbx_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [mbx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbx_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic                            in_action,
  input  logic [mbx_pkg::SENDER_W-1:0]    in_sender_id,
  input  logic [mbx_pkg::LEN_W-1:0]       in_msg_length,
  input  logic [mbx_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_first_beat,
  output mbx_pkg::status_t                out_status,
  output logic [mbx_pkg::SENDER_W-1:0]    out_sender_id,
  output logic [mbx_pkg::LEN_W-1:0]       out_length,
  output logic [mbx_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last,
  output logic [mbx_pkg::CNT_W-1:0]       out_message_count,
  output logic [mbx_pkg::LEN_W-1:0]       out_bytes_in_use
);
  import mbx_pkg::*;

  function automatic logic [BYTE_AW-1:0] adv_byte(input logic [BYTE_AW-1:0] p);
    return (p == BYTE_AW'(BYTE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [MSG_AW-1:0] adv_msg(input logic [MSG_AW-1:0] p);
    return (p == MSG_AW'(MSG_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // latched request beat
  logic                act_r;
  logic [SENDER_W-1:0] sender_r;
  logic [LEN_W-1:0]    len_r;
  logic [BYTE_W-1:0]   data_r;
  logic                first_r;

  // configuration
  logic [CNT_W-1:0] msg_limit_r;
  logic [LEN_W-1:0] byte_limit_r;

  // mailbox state
  logic [BYTE_AW-1:0] wp_r, wp_nxt;
  logic [BYTE_AW-1:0] rp_r, rp_nxt;
  logic [MSG_AW-1:0]  head_r, head_nxt;
  logic [MSG_AW-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]   complete_r, complete_nxt;
  logic [LEN_W-1:0]   reserved_r, reserved_nxt;
  logic               open_r, open_nxt;
  logic               drop_r, drop_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [LEN_W-1:0]   pop_off_r, pop_off_nxt;

  // result register
  status_t             st_r, st_nxt;
  logic [SENDER_W-1:0] o_sender_r, o_sender_nxt;
  logic [LEN_W-1:0]    o_len_r, o_len_nxt;
  logic [BYTE_W-1:0]   o_byte_r, o_byte_nxt;
  logic                o_last_r, o_last_nxt;
  logic [CNT_W-1:0]    o_count_r, o_count_nxt;
  logic [LEN_W-1:0]    o_bytes_r, o_bytes_nxt;

  // memories
  logic               pay_we;
  logic [BYTE_W-1:0]  pay_rdata;
  logic               desc_we;
  logic [DESC_W-1:0]  desc_rdata;
  logic [SENDER_W-1:0] head_sender;
  logic [LEN_W-1:0]    head_len;

  // scratch
  logic [CNT_W-1:0] mlim;
  logic [LEN_W-1:0] blim;
  logic [LEN_W:0]   byte_sum;
  logic [LEN_W:0]   off_inc;
  logic [LEN_W-1:0] remain_dec;
  logic             finish;

  mbx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BYTE_DEPTH)
  ) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr (wp_r),
    .wdata (data_r),
    .raddr (rp_r),
    .rdata (pay_rdata)
  );

  mbx_ram #(
    .WIDTH (DESC_W),
    .DEPTH (MSG_DEPTH)
  ) u_desc (
    .clk   (clk),
    .we    (desc_we),
    .waddr (tail_r),
    .wdata ({sender_r, len_r}),
    .raddr (head_r),
    .rdata (desc_rdata)
  );

  assign head_sender = desc_rdata[DESC_W-1:LEN_W];
  assign head_len    = desc_rdata[LEN_W-1:0];

  // request capture and result register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r    <= in_action;
      sender_r <= in_sender_id;
      len_r    <= in_msg_length;
      data_r   <= in_data_byte;
      first_r  <= in_first_beat;
    end
    if (cmd.commit) begin
      st_r       <= st_nxt;
      o_sender_r <= o_sender_nxt;
      o_len_r    <= o_len_nxt;
      o_byte_r   <= o_byte_nxt;
      o_last_r   <= o_last_nxt;
      o_count_r  <= o_count_nxt;
      o_bytes_r  <= o_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_limit_r  <= MSG_LIMIT_RST;
      byte_limit_r <= BYTE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MSG_LIMIT:  msg_limit_r  <= cfg_wdata[CNT_W-1:0];
        CFG_BYTE_LIMIT: byte_limit_r <= cfg_wdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      complete_r <= '0;
      reserved_r <= '0;
      open_r     <= 1'b0;
      drop_r     <= 1'b0;
      remain_r   <= '0;
      pop_off_r  <= '0;
    end else if (cmd.commit) begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      complete_r <= complete_nxt;
      reserved_r <= reserved_nxt;
      open_r     <= open_nxt;
      drop_r     <= drop_nxt;
      remain_r   <= remain_nxt;
      pop_off_r  <= pop_off_nxt;
    end
  end

  assign mlim = (msg_limit_r < CNT_W'(MSG_DEPTH)) ? msg_limit_r : CNT_W'(MSG_DEPTH);
  assign blim = (byte_limit_r < LEN_W'(BYTE_DEPTH)) ? byte_limit_r : LEN_W'(BYTE_DEPTH);
  assign byte_sum   = {1'b0, reserved_r} + {1'b0, len_r};
  assign remain_dec = (remain_r != '0) ? remain_r - 1'b1 : remain_r;

  always_comb begin
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    complete_nxt = complete_r;
    reserved_nxt = reserved_r;
    open_nxt     = open_r;
    drop_nxt     = drop_r;
    remain_nxt   = remain_r;
    pop_off_nxt  = pop_off_r;
    pay_we       = 1'b0;
    desc_we      = 1'b0;
    finish       = 1'b0;
    off_inc      = {1'b0, pop_off_r};
    st_nxt       = ST_OK;
    o_sender_nxt = '0;
    o_len_nxt    = '0;
    o_byte_nxt   = '0;
    o_last_nxt   = 1'b0;

    if (act_r == ACT_POP) begin
      if (complete_r == '0) begin
        st_nxt = ST_EMPTY;
      end else begin
        o_sender_nxt = head_sender;
        o_len_nxt    = head_len;
        if (head_len != '0) begin
          o_byte_nxt = pay_rdata;
          rp_nxt     = adv_byte(rp_r);
          off_inc    = {1'b0, pop_off_r} + 1'b1;
        end
        if (off_inc >= {1'b0, head_len}) begin
          // last byte: free the message and its reservation
          o_last_nxt   = 1'b1;
          reserved_nxt = (reserved_r >= head_len) ? reserved_r - head_len : '0;
          head_nxt     = adv_msg(head_r);
          complete_nxt = complete_r - 1'b1;
          pop_off_nxt  = '0;
        end else begin
          pop_off_nxt = off_inc[LEN_W-1:0];
        end
      end
    end else if (first_r) begin
      if (open_r && !drop_r) begin
        st_nxt = ST_IGNORED;
      end else begin
        open_nxt   = 1'b0;
        drop_nxt   = 1'b0;
        remain_nxt = '0;
        if (complete_r >= mlim) begin
          st_nxt = ST_COUNT_FULL;
        end else if (byte_sum > {1'b0, blim}) begin
          st_nxt = ST_BYTES_FULL;
        end
        if (st_nxt != ST_OK) begin
          // rejected: swallow the rest of the message
          if (len_r > LEN_W'(1)) begin
            open_nxt   = 1'b1;
            drop_nxt   = 1'b1;
            remain_nxt = len_r - 1'b1;
          end
        end else begin
          desc_we = 1'b1;
          if (len_r == '0) begin
            finish = 1'b1;
          end else begin
            pay_we       = 1'b1;
            wp_nxt       = adv_byte(wp_r);
            reserved_nxt = byte_sum[LEN_W-1:0];
            remain_nxt   = len_r - 1'b1;
            if (len_r == LEN_W'(1)) begin
              finish = 1'b1;
            end else begin
              open_nxt = 1'b1;
            end
          end
        end
      end
    end else if (!open_r) begin
      st_nxt = ST_IGNORED;
    end else if (drop_r) begin
      st_nxt     = ST_IGNORED;
      remain_nxt = remain_dec;
      if (remain_dec == '0) begin
        open_nxt = 1'b0;
        drop_nxt = 1'b0;
      end
    end else begin
      pay_we     = 1'b1;
      wp_nxt     = adv_byte(wp_r);
      remain_nxt = remain_dec;
      if (remain_dec == '0) begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      tail_nxt     = adv_msg(tail_r);
      complete_nxt = complete_r + 1'b1;
      open_nxt     = 1'b0;
      drop_nxt     = 1'b0;
      remain_nxt   = '0;
    end

    pay_we  = pay_we && cmd.commit;
    desc_we = desc_we && cmd.commit;

    o_count_nxt = complete_nxt + CNT_W'(open_nxt && !drop_nxt);
    o_bytes_nxt = reserved_nxt;
  end

  assign out_status        = st_r;
  assign out_sender_id     = o_sender_r;
  assign out_length        = o_len_r;
  assign out_byte          = o_byte_r;
  assign out_last          = o_last_r;
  assign out_message_count = o_count_r;
  assign out_bytes_in_use  = o_bytes_r;

endmodule

### hw/rtl/bounded_message_mailbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_message_mailbox
// FIFO mailbox of tagged byte messages with message-count and byte limits.
// ----------------------------------------------------------------------------
// Each request beat (push beat or pop) gives exactly one result beat. A beat
// has an accept cycle, in which the payload and descriptor RAMs are read at
// the current read pointer and queue head, and a commit cycle that applies
// the beat once that registered read data is back and loads the result
// register. The next beat is accepted while a result still waits at the
// output; the commit then holds until that result is taken. RAM contents
// need no clearing after reset: the block is ready as soon as reset ends.
// Limits are to be written through the cfg_ port only while the block is
// idle (the block does not enforce this) and affect only later admissions.
// ----------------------------------------------------------------------------
module bounded_message_mailbox (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mbx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbx_pkg::CFG_DW-1:0]    cfg_wdata,
  mbx_in_if.sink                        in_if,
  mbx_out_if.source                     out_if
);
  import mbx_pkg::*;

  mbx_cmd_t cmd;

  mbx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  mbx_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_if.action),
    .in_sender_id      (in_if.sender_id),
    .in_msg_length     (in_if.msg_length),
    .in_data_byte      (in_if.data_byte),
    .in_first_beat     (in_if.first_beat),
    .out_status        (out_if.status),
    .out_sender_id     (out_if.out_sender_id),
    .out_length        (out_if.out_length),
    .out_byte          (out_if.out_byte),
    .out_last          (out_if.out_last),
    .out_message_count (out_if.message_count),
    .out_bytes_in_use  (out_if.bytes_in_use)
  );

endmodule

### tb/sv/tb_bounded_message_mailbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_message_mailbox
// Self-checking bench for the message mailbox. A short directed run covers
// the admission corner cases. Random traffic of whole messages, pops and
// stray or broken beats follows. It runs under several limit settings and
// with the request side idling and the result side stalling in turn. A
// shadow mailbox predicts every result beat, and each one is compared
// field by field.
// ----------------------------------------------------------------------------
module tb_bounded_message_mailbox;
  import mbx_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 8;

  typedef struct packed {
    logic                action;
    logic [SENDER_W-1:0] sender;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data;
    logic                first;
  } mbx_beat_t;

  typedef struct packed {
    status_t             status;
    logic [SENDER_W-1:0] sender;
    logic [LEN_W-1:0]    length;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [CNT_W-1:0]    count;
    logic [LEN_W-1:0]    bytes;
  } mbx_resp_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_wdata;

  mbx_in_if  in_ch ();
  mbx_out_if out_ch ();

  bounded_message_mailbox dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mbx_beat_t beat_queue[$];
  mbx_resp_t resp_expected[$];
  int        fail_count   = 0;
  int        cycle_count  = 0;
  int        idle_in_pct  = 0;
  int        stall_out_pct = 0;
  bit        beat_taken   = 1'b0;

  // Shadow mailbox; pointer widths wrap exactly like the block's rings
  logic [BYTE_W-1:0]   ring_mem [BYTE_DEPTH];
  logic [BYTE_AW-1:0]  wr_ptr = '0;
  logic [BYTE_AW-1:0]  rd_ptr = '0;
  logic [SENDER_W-1:0] desc_sender [MSG_DEPTH];
  logic [LEN_W-1:0]    desc_len [MSG_DEPTH];
  logic [MSG_AW-1:0]   desc_head = '0;
  logic [MSG_AW-1:0]   desc_tail = '0;
  logic [CNT_W-1:0]    done_msgs = '0;
  logic [LEN_W-1:0]    resv_bytes = '0;
  logic                push_busy = 1'b0;
  logic                push_drop = 1'b0;
  logic [LEN_W-1:0]    push_left = '0;
  logic [LEN_W-1:0]    pop_pos = '0;
  logic [CNT_W-1:0]    lim_msgs = MSG_LIMIT_RST;
  logic [LEN_W-1:0]    lim_bytes = BYTE_LIMIT_RST;

  function automatic int held_msgs();
    return int'(done_msgs) + ((push_busy && !push_drop) ? 1 : 0);
  endfunction

  function automatic void close_msg();
    desc_tail++;
    done_msgs++;
    push_busy = 1'b0;
    push_drop = 1'b0;
    push_left = '0;
  endfunction

  function automatic void store_byte(logic [BYTE_W-1:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr++;
  endfunction

  function automatic mbx_resp_t mailbox_apply(mbx_beat_t b);
    mbx_resp_t        r;
    int               mlim;
    int               blim;
    logic [LEN_W-1:0] mlen;
    r = '0;
    if (b.action == ACT_POP) begin
      if (done_msgs == 0) begin
        r.status = ST_EMPTY;
      end else begin
        mlen     = desc_len[desc_head];
        r.sender = desc_sender[desc_head];
        r.length = mlen;
        if (mlen != 0) begin
          r.data = ring_mem[rd_ptr];
          rd_ptr++;
          pop_pos++;
        end
        if (pop_pos >= mlen) begin
          r.last     = 1'b1;
          resv_bytes = (resv_bytes >= mlen) ? resv_bytes - mlen : '0;
          desc_head++;
          done_msgs--;
          pop_pos    = '0;
        end
      end
    end else if (b.first) begin
      if (push_busy && !push_drop) begin
        r.status = ST_IGNORED;
      end else begin
        mlim = (int'(lim_msgs) < MSG_DEPTH) ? int'(lim_msgs) : MSG_DEPTH;
        blim = (int'(lim_bytes) < BYTE_DEPTH) ? int'(lim_bytes) : BYTE_DEPTH;
        push_busy = 1'b0;
        push_drop = 1'b0;
        push_left = '0;
        // count is judged before bytes
        if (held_msgs() >= mlim)
          r.status = ST_COUNT_FULL;
        else if (int'(resv_bytes) + int'(b.length) > blim)
          r.status = ST_BYTES_FULL;
        if (r.status != ST_OK) begin
          if (b.length > 1) begin
            push_busy = 1'b1;
            push_drop = 1'b1;
            push_left = b.length - 1'b1;
          end
        end else begin
          desc_sender[desc_tail] = b.sender;
          desc_len[desc_tail]    = b.length;
          if (b.length == 0) begin
            close_msg();
          end else begin
            store_byte(b.data);
            resv_bytes += b.length;
            push_left  = b.length - 1'b1;
            if (push_left == 0)
              close_msg();
            else
              push_busy = 1'b1;
          end
        end
      end
    end else if (!push_busy) begin
      r.status = ST_IGNORED;
    end else if (push_drop) begin
      r.status = ST_IGNORED;
      if (push_left > 0)
        push_left--;
      if (push_left == 0) begin
        push_busy = 1'b0;
        push_drop = 1'b0;
      end
    end else begin
      store_byte(b.data);
      if (push_left > 0)
        push_left--;
      if (push_left == 0)
        close_msg();
    end
    r.count = CNT_W'(held_msgs());
    r.bytes = resv_bytes;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic logic [SENDER_W-1:0] rand_sender();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 85)
      return $urandom_range(8);
    else if (p < 97)
      return $urandom_range(64, 9);
    return $urandom_range(1024, 65);
  endfunction

  task automatic queue_beat(logic act, logic [SENDER_W-1:0] snd, int len, int data, logic first);
    mbx_beat_t b;
    b.action = act;
    b.sender = snd;
    b.length = LEN_W'(len);
    b.data   = BYTE_W'(data);
    b.first  = first;
    beat_queue.push_back(b);
  endtask

  task automatic queue_pop();
    queue_beat(ACT_POP, rand_sender(), $urandom_range(1024), $urandom_range(255),
               1'($urandom_range(1)));
  endtask

  task automatic queue_body(int data);
    queue_beat(ACT_PUSH, rand_sender(), $urandom_range(1024), data, 1'b0);
  endtask

  task automatic gen_traffic(int target);
    int n;
    int r;
    int k;
    int len;
    int cut;
    int i;
    n = 0;
    while (n < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        k = (r < 8) ? $urandom_range(40, 1) : $urandom_range(8, 1);
        repeat (k) queue_pop();
        n += k;
      end else if (r < 52) begin
        case ($urandom_range(2))
          0: queue_body($urandom_range(255));
          1: queue_pop();
          default: queue_beat(ACT_PUSH, rand_sender(), $urandom_range(1024),
                              $urandom_range(255), 1'b1);
        endcase
        n++;
      end else begin
        len = pick_len();
        // now and then cut a message short
        cut = ($urandom_range(19) == 0) ? $urandom_range(len) : len;
        queue_beat(ACT_PUSH, rand_sender(), len, $urandom_range(255), 1'b1);
        n++;
        for (i = 1; i < cut; i++) begin
          if ($urandom_range(49) == 0) begin
            queue_beat(ACT_PUSH, rand_sender(), pick_len(), $urandom_range(255), 1'b1);
            n++;
          end
          queue_body($urandom_range(255));
          n++;
        end
      end
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_MSG_LIMIT)
      lim_msgs = CNT_W'(val);
    else
      lim_bytes = LEN_W'(val);
  endtask

  task automatic set_phase(int msg_lim, int byte_lim, int idle_pct, int stall_pct);
    write_cfg(CFG_MSG_LIMIT, msg_lim);
    write_cfg(CFG_BYTE_LIMIT, byte_lim);
    idle_in_pct   = idle_pct;
    stall_out_pct = stall_pct;
  endtask

  task automatic wait_drained();
    while (beat_queue.size() != 0 || in_ch.valid || resp_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Request driver: new beat at the falling edge once the last one is taken
  always @(negedge clk) begin
    mbx_beat_t nb;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= ACT_PUSH;
      in_ch.sender_id  <= '0;
      in_ch.msg_length <= '0;
      in_ch.data_byte  <= '0;
      in_ch.first_beat <= 1'b0;
      out_ch.ready     <= 1'b0;
    end else begin
      if (!in_ch.valid || beat_taken) begin
        if (beat_queue.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
          nb = beat_queue[0];
          beat_queue.delete(0);
          in_ch.valid      <= 1'b1;
          in_ch.action     <= nb.action;
          in_ch.sender_id  <= nb.sender;
          in_ch.msg_length <= nb.length;
          in_ch.data_byte  <= nb.data;
          in_ch.first_beat <= nb.first;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_out_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    mbx_beat_t b;
    mbx_resp_t want;
    if (rst_n) begin
      beat_taken = in_ch.valid && in_ch.ready;
      if (beat_taken) begin
        b.action = in_ch.action;
        b.sender = in_ch.sender_id;
        b.length = in_ch.msg_length;
        b.data   = in_ch.data_byte;
        b.first  = in_ch.first_beat;
        resp_expected.push_back(mailbox_apply(b));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (resp_expected.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got status %0d", $time,
                   out_ch.status);
          fail_count++;
        end else begin
          want = resp_expected[0];
          resp_expected.delete(0);
          check_field("status", 64'(want.status), 64'(out_ch.status));
          check_field("sender", want.sender, out_ch.out_sender_id);
          check_field("length", 64'(want.length), 64'(out_ch.out_length));
          check_field("byte", 64'(want.data), 64'(out_ch.out_byte));
          check_field("last", 64'(want.last), 64'(out_ch.out_last));
          check_field("message_count", 64'(want.count), 64'(out_ch.message_count));
          check_field("bytes_in_use", 64'(want.bytes), 64'(out_ch.bytes_in_use));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: corner cases of admission, dropping and popping
    set_phase(16, 1024, 0, 0);
    queue_pop();
    queue_body(8'h11);
    queue_beat(ACT_PUSH, '1, 0, 8'hFF, 1'b1);
    queue_beat(ACT_PUSH, '0, 1, 8'hFF, 1'b1);
    queue_beat(ACT_PUSH, 64'h0123_4567_89AB_CDEF, 3, 8'h00, 1'b1);
    queue_beat(ACT_PUSH, 64'hFEDC_BA98_7654_3210, 2, 8'h77, 1'b1);
    queue_body(8'hA5);
    queue_body(8'h5A);
    queue_beat(ACT_PUSH, 64'h8000_0000_0000_0001, 1024, 8'h81, 1'b1);
    queue_body(8'h42);
    queue_beat(ACT_PUSH, 64'h5555_AAAA_5555_AAAA, 2, 8'h3C, 1'b1);
    queue_body(8'hC3);
    repeat (8) queue_pop();
    wait_drained();

    // Directed: zero limits, count full takes priority over bytes full
    set_phase(0, 0, 0, 0);
    queue_beat(ACT_PUSH, 64'hAAAA_5555_AAAA_5555, 5, 8'h01, 1'b1);
    queue_body(8'h02);
    queue_beat(ACT_PUSH, 64'h0000_0000_FFFF_FFFF, 0, 8'h00, 1'b1);
    wait_drained();

    set_phase(16, 1024, 0, 0);
    gen_traffic(225);
    wait_drained();

    set_phase(3, 40, 84, 0);
    gen_traffic(225);
    wait_drained();

    set_phase(8, 1024, 0, 84);
    gen_traffic(225);
    wait_drained();

    set_phase(16, 200, 36, 36);
    gen_traffic(225);
    wait_drained();

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
